/* src/ctp_pkg.sv */
package ctp_pkg;

  localparam int unsigned PACK_TEXT_BYTES = 12;
  localparam int unsigned PACK_HEAD_TEXT  = 16;
  localparam int unsigned PACK_TOTAL      = 18;

  localparam int unsigned RAM_WIDTH = 8;
  localparam int unsigned RAM_DEPTH = 32;
  localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);

  localparam logic [1:0] OP_TEXT    = 2'd0;
  localparam logic [1:0] OP_FLUSH   = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic       REG_CRC_POLY   = 1'b0;
  localparam logic [15:0] CRC_POLY_RESET = 16'h1021;
  localparam logic [15:0] CRC_INVERT     = 16'hFFFF;

  localparam logic [3:0] FILL_LAST   = 4'(PACK_TEXT_BYTES - 1);
  localparam logic [3:0] FILL_FULL   = 4'(PACK_TEXT_BYTES);
  localparam logic [3:0] CHAR_POS_MAX = 4'd15;

  localparam logic [4:0] IDX_TEXT_FIRST = 5'd4;
  localparam logic [4:0] IDX_READ_FIRST = 5'd3;
  localparam logic [4:0] IDX_READ_LAST  = 5'(PACK_HEAD_TEXT - 2);
  localparam logic [4:0] IDX_CRC_HI     = 5'(PACK_HEAD_TEXT);
  localparam logic [4:0] IDX_LAST       = 5'(PACK_TOTAL - 1);

  typedef struct packed {
    logic       valid;
    logic [7:0] ptype;
    logic [7:0] track;
    logic [7:0] seq;
    logic [3:0] pos;
    logic [3:0] count;
    logic       bank;
  } ctp_emit_req_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* src/cd_text_pack_framer.sv */
// CD-Text pack framer.
// The input stream carries one word per text character: in_tuser holds the
// operation (text byte, flush or restart) and in_tdata the pack type, track
// number and character. Every twelve text bytes form one 18-byte pack that
// leaves on the output stream one byte per word, header first, the inverted
// CRC-16 last, with out_tlast on the low CRC byte. A flush sends a partly
// filled pack padded with zeros; a restart clears the sequence number.
// Text bytes are written into a two-bank buffer memory, so a new pack fills
// one bank while the other is read out. Accepting the word that completes a
// pack starts the emitter, which then registers the pack bytes into the output
// word one byte per cycle while the receiver is ready. A word that would
// complete a pack waits while the previous pack is still being sent. When the
// receiver stalls, the output word holds and the pack readout pauses. The CRC
// polynomial register (address 0) resets to 0x1021; the user must write it
// only while the block is idle, and the block itself does not enforce this.
// Synchronous reset clears all counters and drops any pack in progress.
module cd_text_pack_framer import ctp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // pack_type, track_number, text_byte
  input  logic [1:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // pack_byte
  output logic        out_tlast,  // last_of_pack
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [15:0] crc_poly_r;
  logic [3:0]  fill_r, fill_nxt;
  logic [7:0]  ftype_r, ftype_nxt, ftrack_r, ftrack_nxt;
  logic [3:0]  fpos_r, fpos_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [3:0]  scc_r, scc_nxt;
  logic        wbank_r, wbank_nxt;

  logic [1:0]  op;
  logic [7:0]  in_type, in_track, in_char;
  logic        would_emit, in_accept, emit_busy;
  logic        wr_en;
  ctp_emit_req_t req;

  logic                 rd_en;
  logic [RAM_AW-1:0]    rd_addr;
  logic [RAM_WIDTH-1:0] rd_data;

  assign op       = in_tuser;
  assign in_type  = in_tdata[7:0];
  assign in_track = in_tdata[15:8];
  assign in_char  = in_tdata[23:16];

  assign would_emit = ((op == OP_TEXT) && (fill_r == FILL_LAST)) ||
                      ((op == OP_FLUSH) && (fill_r != 4'd0));
  assign in_tready  = !emit_busy || !would_emit;
  assign in_accept  = in_tvalid && in_tready;
  assign wr_en      = in_accept && (op == OP_TEXT);

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_CRC_POLY) ? {16'h0000, crc_poly_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_poly_r <= CRC_POLY_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == REG_CRC_POLY)) begin
      crc_poly_r <= cfg_pwdata[15:0];
    end
  end

  always_comb begin
    fill_nxt   = fill_r;
    ftype_nxt  = ftype_r;
    ftrack_nxt = ftrack_r;
    fpos_nxt   = fpos_r;
    seq_nxt    = seq_r;
    scc_nxt    = scc_r;
    wbank_nxt  = wbank_r;
    req.valid  = 1'b0;
    req.ptype  = ftype_r;
    req.track  = ftrack_r;
    req.seq    = seq_r;
    req.pos    = fpos_r;
    req.count  = fill_r;
    req.bank   = wbank_r;
    if (in_accept) begin
      case (op)
        OP_TEXT: begin
          if (fill_r == 4'd0) begin
            ftype_nxt  = in_type;
            ftrack_nxt = in_track;
            fpos_nxt   = scc_r;
          end
          if (in_char == 8'h00) begin
            scc_nxt = 4'd0;
          end else if (scc_r != CHAR_POS_MAX) begin
            scc_nxt = scc_r + 4'd1;
          end
          if (fill_r == FILL_LAST) begin
            req.valid = 1'b1;
            req.count = FILL_FULL;
            seq_nxt   = seq_r + 8'd1;
            fill_nxt  = 4'd0;
            wbank_nxt = !wbank_r;
          end else begin
            fill_nxt = fill_r + 4'd1;
          end
        end
        OP_FLUSH: begin
          if (fill_r != 4'd0) begin
            req.valid = 1'b1;
            seq_nxt   = seq_r + 8'd1;
            wbank_nxt = !wbank_r;
          end
          fill_nxt = 4'd0;
          scc_nxt  = 4'd0;
        end
        OP_RESTART: begin
          seq_nxt    = 8'd0;
          fill_nxt   = 4'd0;
          scc_nxt    = 4'd0;
          ftype_nxt  = 8'd0;
          ftrack_nxt = 8'd0;
          fpos_nxt   = 4'd0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= 4'd0;
      ftype_r  <= 8'd0;
      ftrack_r <= 8'd0;
      fpos_r   <= 4'd0;
      seq_r    <= 8'd0;
      scc_r    <= 4'd0;
      wbank_r  <= 1'b0;
    end else begin
      fill_r   <= fill_nxt;
      ftype_r  <= ftype_nxt;
      ftrack_r <= ftrack_nxt;
      fpos_r   <= fpos_nxt;
      seq_r    <= seq_nxt;
      scc_r    <= scc_nxt;
      wbank_r  <= wbank_nxt;
    end
  end

  ctp_ram #(
    .WIDTH (RAM_WIDTH),
    .DEPTH (RAM_DEPTH)
  ) u_text_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr ({wbank_r, fill_r}),
    .wr_data (in_char),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ctp_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .crc_poly   (crc_poly_r),
    .busy       (emit_busy),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_LAST)
    else $error("text buffer fill count out of range");
  a_bank_swap: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid |=> (wbank_r != $past(wbank_r)) && (fill_r == 4'd0))
    else $error("buffer bank not swapped after a pack request");
  a_no_read_of_fill_bank: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en && wr_en |-> (rd_addr[RAM_AW-1] != wbank_r))
    else $error("pack readout collides with the bank being filled");
`endif

endmodule

/* src/ctp_ram.sv */
module ctp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/ctp_emitter.sv */
module ctp_emitter import ctp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  ctp_emit_req_t       req,
  input  logic [15:0]         crc_poly,
  output logic                busy,
  output logic                rd_en,
  output logic [RAM_AW-1:0]   rd_addr,
  input  logic [RAM_WIDTH-1:0] rd_data,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,  // pack_byte
  output logic                out_tlast   // last_of_pack
);

  logic        active_r, active_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  ptype_r, track_r, seq_r;
  logic [3:0]  pos_r, count_r;
  logic        bank_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_data_r;
  logic        out_last_r;
  logic        advance;
  logic [7:0]  byte_val;
  logic [3:0]  text_idx;
  logic [4:0]  read_idx;

  assign advance  = active_r && (!out_valid_r || out_tready);
  assign text_idx = 4'(idx_r - IDX_TEXT_FIRST);
  assign read_idx = idx_r - IDX_READ_FIRST;
  assign rd_en    = advance && (idx_r >= IDX_READ_FIRST) && (idx_r <= IDX_READ_LAST);
  assign rd_addr  = {bank_r, read_idx[3:0]};

  always_comb begin
    if (idx_r == 5'd0) begin
      byte_val = ptype_r;
    end else if (idx_r == 5'd1) begin
      byte_val = track_r;
    end else if (idx_r == 5'd2) begin
      byte_val = seq_r;
    end else if (idx_r == IDX_READ_FIRST) begin
      byte_val = {4'b0000, pos_r};
    end else if (idx_r == IDX_CRC_HI) begin
      byte_val = ~crc_r[15:8];
    end else if (idx_r == IDX_LAST) begin
      byte_val = ~crc_r[7:0];
    end else if (text_idx < count_r) begin
      byte_val = rd_data;
    end else begin
      byte_val = 8'h00;
    end
  end

  always_comb begin
    active_nxt    = active_r;
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (req.valid) begin
      active_nxt = 1'b1;
      idx_nxt    = 5'd0;
      crc_nxt    = 16'h0000;
    end else if (advance) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = idx_r + 5'd1;
      if (idx_r < IDX_CRC_HI) begin
        crc_nxt = crc_byte(crc_r, byte_val, crc_poly);
      end
      if (idx_r == IDX_LAST) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    crc_r <= crc_nxt;
    if (req.valid) begin
      ptype_r <= req.ptype;
      track_r <= req.track;
      seq_r   <= req.seq;
      pos_r   <= req.pos;
      count_r <= req.count;
      bank_r  <= req.bank;
    end
    if (advance) begin
      out_data_r <= byte_val;
      out_last_r <= (idx_r == IDX_LAST);
    end
  end

  assign busy       = active_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_req_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid |-> !active_r)
    else $error("pack request while a pack is still being sent");
  a_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (idx_r == IDX_LAST) |=> out_tvalid && out_tlast && !active_r)
    else $error("final pack word not marked as last");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (idx_r <= IDX_LAST))
    else $error("pack byte index out of range");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (count_r != 4'd0) && (count_r <= FILL_FULL))
    else $error("pack started without text");
`endif

endmodule

/* dv/cd_text_pack_framer_checker.sv */
`timescale 1ns / 100ps

module cd_text_pack_framer_checker import ctp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // pack_type, track_number, text_byte
  input  logic [1:0]  in_tuser,   // operation
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // pack_byte
  input  logic        out_tlast,  // last_of_pack
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          pending,
  output int          failures,
  output int          checked
);

  localparam logic [2:0] POLY_ADDR = 3'(4 * REG_CRC_POLY);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pack_word_t;

  pack_word_t  pack_words_q[$];
  pack_word_t  want;
  logic [7:0]  text_q [PACK_TEXT_BYTES];
  logic [3:0]  fill;
  logic [3:0]  char_count;
  logic [3:0]  first_pos;
  logic [7:0]  first_type;
  logic [7:0]  first_track;
  logic [7:0]  seq_num;
  logic [15:0] poly;
  int          errors = 0;
  int          words_checked = 0;

  initial begin
    pending  = 0;
    failures = 0;
    checked  = 0;
  end

  function automatic void queue_pack();
    logic [7:0]  bytes [PACK_TOTAL];
    logic [15:0] crc;
    pack_word_t  item;
    bytes[0] = first_type;
    bytes[1] = first_track;
    bytes[2] = seq_num;
    bytes[3] = {4'd0, first_pos};
    for (int i = 0; i < PACK_TEXT_BYTES; i++) begin
      bytes[4 + i] = (i < fill) ? text_q[i] : 8'd0;
    end
    crc = '0;
    for (int i = 0; i < PACK_HEAD_TEXT; i++) begin
      crc = crc ^ {bytes[i], 8'd0};
      for (int b = 0; b < 8; b++) begin
        crc = crc[15] ? ({crc[14:0], 1'b0} ^ poly) : {crc[14:0], 1'b0};
      end
    end
    crc = crc ^ CRC_INVERT;
    bytes[PACK_HEAD_TEXT]     = crc[15:8];
    bytes[PACK_HEAD_TEXT + 1] = crc[7:0];
    for (int i = 0; i < PACK_TOTAL; i++) begin
      item.data    = bytes[i];
      item.last    = 1'(i == PACK_TOTAL - 1);
      pack_words_q = {pack_words_q, item};
    end
    seq_num = seq_num + 8'd1;
    fill    = '0;
  endfunction

  function automatic void take_word(input logic [1:0] op, input logic [23:0] word);
    logic [7:0] ptype;
    logic [7:0] track;
    logic [7:0] ch;
    ptype = word[7:0];
    track = word[15:8];
    ch    = word[23:16];
    case (op)
      OP_TEXT: begin
        if (fill == 4'd0) begin
          first_type  = ptype;
          first_track = track;
          first_pos   = char_count;
        end
        text_q[fill] = ch;
        fill = fill + 4'd1;
        if (ch == 8'd0) begin
          char_count = '0;
        end else if (char_count != CHAR_POS_MAX) begin
          char_count = char_count + 4'd1;
        end
        if (fill == FILL_FULL) begin
          queue_pack();
        end
      end
      OP_FLUSH: begin
        if (fill != 4'd0) begin
          queue_pack();
        end
        fill       = '0;
        char_count = '0;
      end
      OP_RESTART: begin
        seq_num     = '0;
        fill        = '0;
        char_count  = '0;
        first_type  = '0;
        first_track = '0;
        first_pos   = '0;
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pack_words_q.delete();
      fill        = '0;
      char_count  = '0;
      first_pos   = '0;
      first_type  = '0;
      first_track = '0;
      seq_num     = '0;
      poly        = CRC_POLY_RESET;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == POLY_ADDR) begin
        poly = cfg_pwdata[15:0];
      end
      if (out_tvalid && out_tready) begin
        words_checked++;
        if (pack_words_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("Unexpected output word: data %02h last %0b with nothing outstanding",
                     out_tdata, out_tlast);
          end
        end else begin
          want = pack_words_q.pop_front();
          if (out_tdata !== want.data || out_tlast !== want.last) begin
            errors++;
            if (errors <= 10) begin
              $display("Word %0d: expected data %02h last %0b, got data %02h last %0b",
                       words_checked, want.data, want.last, out_tdata, out_tlast);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        take_word(in_tuser, in_tdata);
      end
    end
    pending  <= pack_words_q.size();
    failures <= errors;
    checked  <= words_checked;
  end

endmodule

/* dv/cd_text_pack_framer_tb.sv */
`timescale 1ns / 100ps

module cd_text_pack_framer_tb;
  import ctp_pkg::*;

  localparam logic [1:0] OP_IGNORED     = 2'd3;
  localparam logic [2:0] POLY_ADDR      = 3'(4 * REG_CRC_POLY);
  localparam int         WATCHDOG_LIMIT = 3000;
  localparam int         HOLD_CYCLES    = 200;
  localparam int         HOLD_AFTER     = 60;
  localparam int         SETTLE_CYCLES  = 10;
  localparam int         DRAIN_CYCLES   = 40;
  localparam int         SHORT_PACKS    = 10;
  localparam int         PHASE_WORDS    = 40;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata    = '0;
  logic [1:0]  in_tuser    = OP_TEXT;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int          pending;
  int          failures;
  int          checked;
  int          words_sent  = 0;
  bit          quiet       = 1'b0;
  bit          held        = 1'b0;
  logic [15:0] odd_poly;

  cd_text_pack_framer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  cd_text_pack_framer_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .pending     (pending),
    .failures    (failures),
    .checked     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic send_word(input logic [1:0] op, input logic [7:0] ptype,
                           input logic [7:0] track, input logic [7:0] ch);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {ch, track, ptype};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_poly(input logic [15:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= POLY_ADDR;
    cfg_pwdata  <= {16'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic random_phase(input int target);
    int         done;
    int         len;
    int         pick;
    logic [7:0] ptype;
    logic [7:0] track;
    done = 0;
    while (done < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        len   = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 10);
        ptype = 8'($urandom);
        track = 8'($urandom);
        repeat (len) send_word(OP_TEXT, ptype, track, 8'($urandom_range(1, 255)));
        send_word(OP_TEXT, ptype, track, 8'h00);
        done += len + 1;
      end else if (pick < 88) begin
        send_word(OP_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
        done++;
      end else if (pick < 93) begin
        send_word(OP_RESTART, 8'($urandom), 8'($urandom), 8'($urandom));
        done++;
      end else if (pick < 97) begin
        send_word(OP_IGNORED, 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        send_word(OP_TEXT, 8'($urandom), 8'($urandom), 8'($urandom));
        done++;
      end
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!held && words_sent >= HOLD_AFTER) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Watchdog expired: no handshake for %0d cycles, %0d words outstanding",
             WATCHDOG_LIMIT, pending);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(OP_FLUSH, 8'h00, 8'h00, 8'h00);
    send_word(OP_IGNORED, 8'hFF, 8'hFF, 8'hFF);
    send_word(OP_TEXT, 8'hFF, 8'hFF, 8'hFF);
    send_word(OP_TEXT, 8'h00, 8'h00, 8'h41);
    send_word(OP_TEXT, 8'h00, 8'h00, 8'h42);
    send_word(OP_TEXT, 8'h00, 8'h00, 8'h00);
    for (int i = 0; i < 8; i++) begin
      send_word(OP_TEXT, 8'h80, 8'h01, 8'(8'h43 + i));
    end
    repeat (3) send_word(OP_TEXT, 8'h80, 8'h01, 8'h78);
    send_word(OP_FLUSH, 8'h00, 8'h00, 8'h00);
    send_word(OP_TEXT, 8'h01, 8'h02, 8'h7F);
    send_word(OP_TEXT, 8'h01, 8'h02, 8'h01);
    send_word(OP_RESTART, 8'h00, 8'h00, 8'h00);
    send_word(OP_TEXT, 8'h10, 8'h20, 8'h55);
    send_word(OP_FLUSH, 8'h00, 8'h00, 8'h00);

    settle();
    write_poly(16'h0000);
    random_phase(PHASE_WORDS);

    settle();
    write_poly(16'hFFFF);
    random_phase(PHASE_WORDS);

    settle();
    odd_poly = 16'($urandom);
    write_poly(odd_poly);
    send_word(OP_RESTART, 8'($urandom), 8'($urandom), 8'($urandom));
    repeat (SHORT_PACKS) begin
      send_word(OP_TEXT, 8'($urandom), 8'($urandom), 8'($urandom));
      send_word(OP_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
    end

    settle();
    write_poly(16'h8005);
    random_phase(PHASE_WORDS);

    settle();
    write_poly(CRC_POLY_RESET);
    quiet = 1'b1;
    random_phase(PHASE_WORDS);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words, checked %0d pack bytes, with one-byte packs back to back.",
             words_sent, checked);
    $display("Polynomials 1021, 0000, FFFF, %04h and 8005 were used, with one long output stall.",
             odd_poly);
    if (failures == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* cd_text_pack_framer.f */
src/ctp_pkg.sv
src/ctp_ram.sv
src/ctp_emitter.sv
src/cd_text_pack_framer.sv
dv/cd_text_pack_framer_checker.sv
dv/cd_text_pack_framer_tb.sv
